// File: hw/rtl/median_filter_3x3_core_macros.svh
// ----------------------------------------------------------------------------
// median filter 3x3 core assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_CORE_MACROS_SVH
`define MEDIAN_FILTER_3X3_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property holds on every clock edge
`define MF3_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mf3 assertion failed");
// consequent holds in the cycle after the antecedent
`define MF3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mf3 assertion failed");
`else
`define MF3_ASSERT(label, prop)
`define MF3_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// shared constants and types of the 3x3 median filter core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mf3_pkg;

  // default parameter values
  localparam int DefMaxWidth  = 1024;
  localparam int DefPixelBits = 8;

  // field widths
  localparam int CenterColW   = 10;
  localparam int RowW         = 12;
  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 12;
  localparam int CfgDataW     = 12;

  // register reset values and limits
  localparam int RstFrameWidth  = 640;
  localparam int RstFrameHeight = 480;
  localparam int MinFrameDim    = 3;

  // configuration register indexes
  typedef enum logic {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  // position data that travels with a pixel through the pipeline
  typedef struct packed {
    logic [CenterColW-1:0] center_col;
    logic [RowW-1:0]       center_row;
    logic                  last_of_frame;
  } side_t;

endpackage

// File: hw/rtl/mf3_line_buffer.sv
// ----------------------------------------------------------------------------
// mf3_line_buffer
// two line stores in one synchronous memory, read at accept, written back as
// the stage advances, forwarded when consecutive pixels hit the same column
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf3_line_buffer #(
  parameter int MAX_WIDTH  = mf3_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = mf3_pkg::DefPixelBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         push_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  logic [PIXEL_BITS-1:0]        pixel_i,
  output logic                         valid_o,
  output logic [PIXEL_BITS-1:0]        top_o,
  output logic [PIXEL_BITS-1:0]        mid_o,
  output logic [PIXEL_BITS-1:0]        pixel_o
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int EntW = 2 * PIXEL_BITS;

  // entry layout: older row in the upper half, newer row in the lower half
  logic [EntW-1:0]       mem_q [MAX_WIDTH];
  logic [EntW-1:0]       rd_q;
  logic [EntW-1:0]       fwd_data_q;
  logic                  fwd_q;
  logic                  valid_q;
  logic [ColW-1:0]       col_q;
  logic [PIXEL_BITS-1:0] pixel_q;

  // column seen by the pixel in this stage
  assign top_o   = fwd_q ? fwd_data_q[EntW-1:PIXEL_BITS] : rd_q[EntW-1:PIXEL_BITS];
  assign mid_o   = fwd_q ? fwd_data_q[PIXEL_BITS-1:0] : rd_q[PIXEL_BITS-1:0];
  assign pixel_o = pixel_q;
  assign valid_o = valid_q;

  // memory read on accept, write back when the stage advances
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rd_q <= mem_q[col_i];
    end
    if (adv_i && valid_q) begin
      mem_q[col_q] <= {mid_o, pixel_q};
    end
  end

  // stage payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      col_q      <= col_i;
      pixel_q    <= pixel_i;
      fwd_data_q <= {mid_o, pixel_q};
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (adv_i) begin
        valid_q <= push_i;
      end
      if (push_i) begin
        fwd_q <= valid_q && (col_q == col_i);
      end
    end
  end

endmodule

// File: hw/rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// three stage median of nine: sort rows, reduce columns, median of three
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mf3_median #(
  parameter int PIXEL_BITS = mf3_pkg::DefPixelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [8:0][PIXEL_BITS-1:0]    win_i,
  input  mf3_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [PIXEL_BITS-1:0]         median_o,
  output mf3_pkg::side_t                side_o
);

  localparam int PB = PIXEL_BITS;

  // returns {high, middle, low}
  function automatic logic [3*PB-1:0] sort3(input logic [PB-1:0] a,
                                            input logic [PB-1:0] b,
                                            input logic [PB-1:0] c);
    logic [PB-1:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return {z, y, x};
  endfunction

  logic [2:0][3*PB-1:0] row_d, row_q;
  logic [PB-1:0]        lo_max_d, mid_med_d, hi_min_d;
  logic [PB-1:0]        lo_max_q, mid_med_q, hi_min_q;
  logic [3*PB-1:0]      mids_s, fin_s;
  logic [PB-1:0]        med_d, med_q;
  logic [2:0]           valid_q;
  mf3_pkg::side_t       side1_q, side2_q, side3_q;

  // stage 1: sort each row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_d[r] = sort3(win_i[3*r], win_i[3*r+1], win_i[3*r+2]);
    end
  end

  // stage 2: max of lows, median of middles, min of highs
  always_comb begin
    lo_max_d = row_q[0][PB-1:0];
    if (row_q[1][PB-1:0] > lo_max_d) lo_max_d = row_q[1][PB-1:0];
    if (row_q[2][PB-1:0] > lo_max_d) lo_max_d = row_q[2][PB-1:0];
    hi_min_d = row_q[0][3*PB-1:2*PB];
    if (row_q[1][3*PB-1:2*PB] < hi_min_d) hi_min_d = row_q[1][3*PB-1:2*PB];
    if (row_q[2][3*PB-1:2*PB] < hi_min_d) hi_min_d = row_q[2][3*PB-1:2*PB];
  end

  assign mids_s    = sort3(row_q[0][2*PB-1:PB], row_q[1][2*PB-1:PB], row_q[2][2*PB-1:PB]);
  assign mid_med_d = mids_s[2*PB-1:PB];

  // stage 3: median of the three candidates
  assign fin_s = sort3(lo_max_q, mid_med_q, hi_min_q);
  assign med_d = fin_s[2*PB-1:PB];

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q     <= row_d;
      side1_q   <= side_i;
      lo_max_q  <= lo_max_d;
      mid_med_q <= mid_med_d;
      hi_min_q  <= hi_min_d;
      side2_q   <= side1_q;
      med_q     <= med_d;
      side3_q   <= side2_q;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o  = valid_q[2];
  assign median_o = med_q;
  assign side_o   = side3_q;

endmodule

// File: hw/rtl/median_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// streaming 3x3 median filter over raster-order grayscale pixels
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_ready_o   pixel_i, frame_start_i
//  out       source     out_valid_o/out_ready_i median_value_o, center_col_o,
//                                               center_row_o, last_of_frame_o
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  one pixel per cycle while in_ready_o is high
//  the line store is one memory read at accept and written back on advance
//  in_ready_o falls only when both the output register and the skid entry hold
//  results, and the whole pipeline then holds
//  no clearing pass after reset: the line store contents are undefined until
//  written, the window, counters and pipeline valids reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "median_filter_3x3_core_macros.svh"

module median_filter_3x3_core #(
  parameter int MAX_WIDTH  = mf3_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = mf3_pkg::DefPixelBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [PIXEL_BITS-1:0]           pixel_i,
  input  logic                            frame_start_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [PIXEL_BITS-1:0]           median_value_o,
  output logic [mf3_pkg::CenterColW-1:0]  center_col_o,
  output logic [mf3_pkg::RowW-1:0]        center_row_o,
  output logic                            last_of_frame_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [mf3_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int RowW     = mf3_pkg::RowW;
  localparam int PB       = PIXEL_BITS;
  localparam int WidthRst = (mf3_pkg::RstFrameWidth > MAX_WIDTH) ? MAX_WIDTH
                                                                 : mf3_pkg::RstFrameWidth;

  // configuration, kept as clamped size minus one
  logic [ColW-1:0] width_m1_q, width_m1_d;
  logic [RowW-1:0] height_m1_q, height_m1_d;
  logic [31:0]     w_req, w_eff;
  logic [RowW-1:0] h_req, h_eff;

  // position counters
  logic [ColW-1:0] col_q, col_d, col_cur, col_m1;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic            wrap;
  logic            emit;
  mf3_pkg::side_t  side_cur;

  // pipeline control
  logic            en;
  logic            accept;
  logic            s1_emit_q;
  mf3_pkg::side_t  s1_side_q;
  logic            lb_valid;
  logic [PB-1:0]   lb_top, lb_mid, lb_px;
  logic [8:0][PB-1:0] win_q;
  logic            win_valid_q;
  mf3_pkg::side_t  win_side_q;
  logic            med_valid;
  logic [PB-1:0]   med_value;
  mf3_pkg::side_t  med_side;

  // output register and skid entry
  logic            out_valid_q, skid_valid_q;
  logic [PB-1:0]   out_med_q, skid_med_q;
  mf3_pkg::side_t  out_side_q, skid_side_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_valid_q;
  assign in_ready_o  = en;
  assign accept      = in_valid_i && en;

  // clamp of written sizes
  always_comb begin
    w_req = 32'(cfg_data_i[mf3_pkg::FrameWidthW-1:0]);
    h_req = cfg_data_i[mf3_pkg::FrameHeightW-1:0];
    if (w_req < 32'(mf3_pkg::MinFrameDim)) begin
      w_eff = 32'(mf3_pkg::MinFrameDim);
    end else if (w_req > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = w_req;
    end
    if (h_req < RowW'(mf3_pkg::MinFrameDim)) begin
      h_eff = RowW'(mf3_pkg::MinFrameDim);
    end else begin
      h_eff = h_req;
    end
  end

  // register write decode
  always_comb begin
    width_m1_d  = width_m1_q;
    height_m1_d = height_m1_q;
    if (cfg_valid_i) begin
      unique case (mf3_pkg::cfg_reg_e'(cfg_index_i))
        mf3_pkg::CfgFrameWidth:  width_m1_d  = ColW'(w_eff - 32'd1);
        mf3_pkg::CfgFrameHeight: height_m1_d = h_eff - RowW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_m1_q  <= ColW'(WidthRst - 1);
      height_m1_q <= RowW'(mf3_pkg::RstFrameHeight - 1);
    end else begin
      width_m1_q  <= width_m1_d;
      height_m1_q <= height_m1_d;
    end
  end

  // position of the incoming pixel and the next one
  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    wrap    = col_cur >= width_m1_q;
    emit    = (col_cur >= ColW'(2)) && (row_cur >= RowW'(2)) &&
              (col_cur <= width_m1_q) && (row_cur <= height_m1_q);
    col_m1  = col_cur - ColW'(1);
    side_cur.center_col    = mf3_pkg::CenterColW'(col_m1);
    side_cur.center_row    = row_cur - RowW'(1);
    side_cur.last_of_frame = (col_cur == width_m1_q) && (row_cur == height_m1_q);
    col_d = wrap ? '0 : col_cur + ColW'(1);
    row_d = row_cur;
    if (wrap) begin
      row_d = (row_cur >= height_m1_q) ? '0 : row_cur + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores
  mf3_line_buffer #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buffer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (en),
    .push_i  (accept),
    .col_i   (col_cur),
    .pixel_i (pixel_i),
    .valid_o (lb_valid),
    .top_o   (lb_top),
    .mid_o   (lb_mid),
    .pixel_o (lb_px)
  );

  // sideband alongside the line store stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_side_q <= side_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q <= 1'b0;
    end else if (en) begin
      s1_emit_q <= accept && emit;
    end
  end

  // 3x3 window, newest column on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      win_valid_q <= 1'b0;
    end else if (en) begin
      win_valid_q <= lb_valid && s1_emit_q;
      if (lb_valid) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= lb_top;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= lb_mid;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= lb_px;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && lb_valid) begin
      win_side_q <= s1_side_q;
    end
  end

  // median network
  mf3_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (win_valid_q),
    .win_i    (win_q),
    .side_i   (win_side_q),
    .valid_o  (med_valid),
    .median_o (med_value),
    .side_o   (med_side)
  );

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_ready_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (med_valid) begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_med_q  <= skid_med_q;
        out_side_q <= skid_side_q;
      end
    end else if (med_valid) begin
      if (!out_valid_q || out_ready_i) begin
        out_med_q  <= med_value;
        out_side_q <= med_side;
      end else begin
        skid_med_q  <= med_value;
        skid_side_q <= med_side;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_value_o  = out_med_q;
  assign center_col_o    = out_side_q.center_col;
  assign center_row_o    = out_side_q.center_row;
  assign last_of_frame_o = out_side_q.last_of_frame;

  // checks
  `MF3_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q)
  `MF3_ASSERT_NEXT(a_skid_fill_on_stall, !skid_valid_q && med_valid && out_valid_q && !out_ready_i, skid_valid_q)
  `MF3_ASSERT(a_last_on_last_row, !(out_valid_o && last_of_frame_o) || (center_row_o == height_m1_q - RowW'(1)))

endmodule
